FILE: hw/rtl/qrsbd_pkg.sv
// Package for the QRS boundary detector: controller states and the
// command and status structs between controller and datapath.
// No dependencies.
package qrsbd_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SETUP,
    ST_GRAD_GO,
    ST_GRAD_RUN,
    ST_SEL_GO,
    ST_SEL_RUN,
    ST_SCAN_GO,
    ST_SCAN_RUN,
    ST_COMMIT,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_GRAD,
    PH_SEL,
    PH_SCAN
  } phase_e;

  // onset segment first, then end segment
  typedef enum logic {
    SEG_ONSET,
    SEG_END
  } seg_e;

  typedef struct packed {
    logic   load;        // sample request taken this cycle
    logic   load_last;   // ... and it closes the beat
    logic   setup;       // latch segment bounds, clear accumulators
    seg_e   seg;
    phase_e phase;
    logic   pass_go;     // restart the address counter
    logic   pass_run;    // step the address counter
    logic   sel_commit;  // settle one bit of the percentile
    logic   seg_commit;  // store this segment's result
    logic   out_load;    // move results to the output register
  } cmd_t;

  typedef struct packed {
    logic pass_done;
    logic short_seg;
    logic bit_zero;
    logic out_free;
  } status_t;

  localparam logic [8:0] WINDOW_RESET = 9'd100;
  localparam int unsigned REG_WINDOW = 0;

endpackage

FILE: hw/rtl/qrsbd_if.sv
// Request channel interfaces: sample input and boundary result output.
// No dependencies.
interface qrsbd_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [30:0]                   seg_start;
  logic [8:0]                    peak_offset;
  logic                          last;

  modport source (output valid, sample, seg_start, peak_offset, last, input ready);
  modport sink   (input valid, sample, seg_start, peak_offset, last, output ready);
endinterface

interface qrsbd_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] onset_index;
  logic        onset_found;
  logic [30:0] end_index;
  logic        end_found;

  modport source (output valid, onset_index, onset_found, end_index, end_found,
                  input ready);
  modport sink   (input valid, onset_index, onset_found, end_index, end_found,
                  output ready);
endinterface

FILE: hw/rtl/qrsbd_ctrl.sv
// Controller state machine of the QRS boundary detector.
// Depends on qrsbd_pkg.
module qrsbd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  qrsbd_pkg::status_t  status_i,
  output qrsbd_pkg::cmd_t     cmd_o
);

  qrsbd_pkg::state_e state_q, state_d;
  qrsbd_pkg::seg_e   seg_q, seg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qrsbd_pkg::ST_LOAD;
      seg_q   <= qrsbd_pkg::SEG_ONSET;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
    end
  end

  always_comb begin
    state_d = state_q;
    seg_d   = seg_q;
    unique case (state_q)
      qrsbd_pkg::ST_LOAD: begin
        if (in_valid_i && in_last_i) begin
          state_d = qrsbd_pkg::ST_SETUP;
          seg_d   = qrsbd_pkg::SEG_ONSET;
        end
      end
      qrsbd_pkg::ST_SETUP: begin
        state_d = status_i.short_seg ? qrsbd_pkg::ST_COMMIT : qrsbd_pkg::ST_GRAD_GO;
      end
      qrsbd_pkg::ST_GRAD_GO: state_d = qrsbd_pkg::ST_GRAD_RUN;
      qrsbd_pkg::ST_GRAD_RUN: begin
        if (status_i.pass_done) state_d = qrsbd_pkg::ST_SEL_GO;
      end
      qrsbd_pkg::ST_SEL_GO: state_d = qrsbd_pkg::ST_SEL_RUN;
      qrsbd_pkg::ST_SEL_RUN: begin
        if (status_i.pass_done) begin
          state_d = status_i.bit_zero ? qrsbd_pkg::ST_SCAN_GO : qrsbd_pkg::ST_SEL_GO;
        end
      end
      qrsbd_pkg::ST_SCAN_GO: state_d = qrsbd_pkg::ST_SCAN_RUN;
      qrsbd_pkg::ST_SCAN_RUN: begin
        if (status_i.pass_done) state_d = qrsbd_pkg::ST_COMMIT;
      end
      qrsbd_pkg::ST_COMMIT: begin
        if (seg_q == qrsbd_pkg::SEG_ONSET) begin
          state_d = qrsbd_pkg::ST_SETUP;
          seg_d   = qrsbd_pkg::SEG_END;
        end else begin
          state_d = qrsbd_pkg::ST_OUT;
        end
      end
      qrsbd_pkg::ST_OUT: begin
        if (status_i.out_free) state_d = qrsbd_pkg::ST_LOAD;
      end
      default: state_d = qrsbd_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.seg   = seg_q;
    cmd_o.phase = qrsbd_pkg::PH_GRAD;
    in_ready_o  = 1'b0;
    unique case (state_q)
      qrsbd_pkg::ST_LOAD: begin
        in_ready_o      = 1'b1;
        cmd_o.load      = in_valid_i;
        cmd_o.load_last = in_valid_i && in_last_i;
      end
      qrsbd_pkg::ST_SETUP: cmd_o.setup = 1'b1;
      qrsbd_pkg::ST_GRAD_GO: cmd_o.pass_go = 1'b1;
      qrsbd_pkg::ST_GRAD_RUN: cmd_o.pass_run = 1'b1;
      qrsbd_pkg::ST_SEL_GO: begin
        cmd_o.phase   = qrsbd_pkg::PH_SEL;
        cmd_o.pass_go = 1'b1;
      end
      qrsbd_pkg::ST_SEL_RUN: begin
        cmd_o.phase      = qrsbd_pkg::PH_SEL;
        cmd_o.pass_run   = 1'b1;
        cmd_o.sel_commit = status_i.pass_done;
      end
      qrsbd_pkg::ST_SCAN_GO: begin
        cmd_o.phase   = qrsbd_pkg::PH_SCAN;
        cmd_o.pass_go = 1'b1;
      end
      qrsbd_pkg::ST_SCAN_RUN: begin
        cmd_o.phase    = qrsbd_pkg::PH_SCAN;
        cmd_o.pass_run = 1'b1;
      end
      qrsbd_pkg::ST_COMMIT: cmd_o.seg_commit = 1'b1;
      qrsbd_pkg::ST_OUT: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

  a_last_starts_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qrsbd_pkg::ST_LOAD && in_valid_i && in_last_i)
      |=> (state_q == qrsbd_pkg::ST_SETUP && seg_q == qrsbd_pkg::SEG_ONSET))
    else $error("beat close did not start the onset segment");

  a_sel_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qrsbd_pkg::ST_SEL_RUN && status_i.pass_done && status_i.bit_zero)
      |=> (state_q == qrsbd_pkg::ST_SCAN_GO))
    else $error("percentile search did not hand over to the scan");

  a_end_after_onset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qrsbd_pkg::ST_OUT) |-> (seg_q == qrsbd_pkg::SEG_END))
    else $error("result released before the end segment was done");

endmodule

FILE: hw/rtl/qrsbd_dp.sv
// Datapath of the QRS boundary detector: sample and gradient stores,
// pass counters, max / percentile / scan logic, output register.
// Depends on qrsbd_pkg.
module qrsbd_dp #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qrsbd_pkg::cmd_t               cmd_i,
  output qrsbd_pkg::status_t            status_o,
  input  logic [8:0]                    window_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [30:0]                   seg_start_i,
  input  logic [8:0]                    peak_offset_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [30:0]                   out_onset_index_o,
  output logic                          out_onset_found_o,
  output logic [30:0]                   out_end_index_o,
  output logic                          out_end_found_o
);

  localparam int DEPTH = 2 * MAX_WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EW    = (CW > 10 ? CW : 10) + 1;
  localparam int GW    = SAMPLE_BITS;
  localparam int BW    = (GW > 1) ? $clog2(GW) : 1;
  localparam int MW    = GW + 5;

  logic signed [GW-1:0] smem [DEPTH];
  logic [GW-1:0]        gmem [DEPTH];

  logic [CW-1:0] cnt_q, len_q, cnt_inc;
  logic [30:0]   base_q;
  logic [8:0]    peak_q;

  // beat loading
  assign cnt_inc = (cnt_q < CW'(DEPTH)) ? cnt_q + CW'(1) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      len_q  <= '0;
      base_q <= '0;
      peak_q <= '0;
    end else if (cmd_i.load) begin
      if (cnt_q == '0) begin
        base_q <= seg_start_i;
        peak_q <= peak_offset_i;
      end
      if (cmd_i.load_last) begin
        len_q <= cnt_inc;
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_inc;
      end
    end
  end

  // segment bounds
  logic [EW-1:0] p_e, w_e, l_e, pw_e, lo_c, hi_c, n_c;
  always_comb begin
    p_e  = EW'(peak_q);
    w_e  = EW'(window_i);
    l_e  = EW'(len_q);
    pw_e = p_e + w_e;
    if (cmd_i.seg == qrsbd_pkg::SEG_ONSET) begin
      lo_c = (p_e > w_e) ? p_e - w_e : '0;
      hi_c = (p_e < l_e) ? p_e : l_e;
    end else begin
      lo_c = p_e;
      hi_c = (pw_e < l_e) ? pw_e : l_e;
    end
    n_c = (hi_c > lo_c) ? hi_c - lo_c : '0;
  end
  assign status_o.short_seg = (n_c < EW'(2));

  logic [EW-1:0] lo_q;
  logic [CW-1:0] n_q, ng, pass_cnt;
  logic [CW-1:0] iss_q, rd_idx_q, sel_cnt_q, kk_q;
  logic          rd_vld_q, issue;
  logic [3:0]    d10_q;
  logic [GW-1:0] max_q, prefix_q, gdata_q, mask;
  logic [BW-1:0] bit_q;
  logic signed [GW-1:0] sdata_q, prev_q;
  logic [AW-1:0] s_addr, g_addr, rd_gaddr_q, pos_q;
  logic          found_q;
  logic [GW:0]   mask_w;

  assign ng       = n_q - CW'(1);
  assign pass_cnt = (cmd_i.phase == qrsbd_pkg::PH_GRAD) ? n_q : ng;
  assign issue    = cmd_i.pass_run && (iss_q < pass_cnt);

  assign status_o.pass_done = (iss_q >= pass_cnt) && !rd_vld_q;
  assign status_o.bit_zero  = (bit_q == '0);

  always_comb begin
    s_addr = AW'(lo_q + EW'(iss_q));
    if (cmd_i.phase == qrsbd_pkg::PH_SCAN && cmd_i.seg == qrsbd_pkg::SEG_ONSET) begin
      g_addr = AW'(ng - CW'(1) - iss_q);  // backward from the last difference
    end else begin
      g_addr = AW'(iss_q);
    end
  end

  // gradient of the arriving sample pair
  logic signed [GW:0] diff;
  logic [GW:0]        adiff;
  logic [GW-1:0]      grad;
  logic               grad_wr;
  assign diff    = (GW+1)'(sdata_q) - (GW+1)'(prev_q);
  assign adiff   = diff[GW] ? -diff : diff;
  assign grad    = adiff[GW-1:0];
  assign grad_wr = rd_vld_q && cmd_i.pass_run && (cmd_i.phase == qrsbd_pkg::PH_GRAD)
                   && (rd_idx_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && cnt_q < CW'(DEPTH)) smem[cnt_q[AW-1:0]] <= sample_i;
    if (grad_wr) gmem[AW'(rd_idx_q - CW'(1))] <= grad;
    sdata_q <= smem[s_addr];
    gdata_q <= gmem[g_addr];
  end

  // percentile: keep elements sharing the settled upper bits
  assign mask_w = {(GW+1){1'b1}} << ({1'b0, bit_q} + (BW+1)'(1));
  assign mask   = mask_w[GW-1:0];

  logic          sel_hit, scan_hit;
  logic [MW-1:0] a10, amul;
  assign sel_hit = ((gdata_q & mask) == (prefix_q & mask)) && !gdata_q[bit_q];
  assign a10     = (MW'(gdata_q) << 3) + (MW'(gdata_q) << 1);
  assign amul    = (cmd_i.seg == qrsbd_pkg::SEG_END) ? (a10 << 1) : a10;
  assign scan_hit = (amul < MW'(max_q)) || (gdata_q < prefix_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q       <= '0;
      n_q        <= '0;
      iss_q      <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      rd_gaddr_q <= '0;
      prev_q     <= '0;
      sel_cnt_q  <= '0;
      kk_q       <= '0;
      d10_q      <= '0;
      max_q      <= '0;
      prefix_q   <= '0;
      bit_q      <= '0;
      found_q    <= 1'b0;
      pos_q      <= '0;
    end else begin
      if (cmd_i.setup) begin
        lo_q     <= lo_c;
        n_q      <= CW'(n_c);
        kk_q     <= '0;
        d10_q    <= '0;
        max_q    <= '0;
        prefix_q <= '0;
        bit_q    <= BW'(GW - 1);
        found_q  <= 1'b0;
        pos_q    <= '0;
      end
      if (cmd_i.pass_go) begin
        iss_q     <= '0;
        rd_vld_q  <= 1'b0;
        sel_cnt_q <= '0;
      end else if (cmd_i.pass_run) begin
        if (issue) iss_q <= iss_q + CW'(1);
        rd_vld_q   <= issue;
        rd_idx_q   <= iss_q;
        rd_gaddr_q <= g_addr;
      end
      if (rd_vld_q && cmd_i.pass_run) begin
        unique case (cmd_i.phase)
          qrsbd_pkg::PH_GRAD: begin
            prev_q <= sdata_q;
            if (grad_wr) begin
              if (grad > max_q) max_q <= grad;
              // k = floor(ng / 10) counted as gradients arrive
              if (d10_q == 4'd9) begin
                d10_q <= '0;
                kk_q  <= kk_q + CW'(1);
              end else begin
                d10_q <= d10_q + 4'd1;
              end
            end
          end
          qrsbd_pkg::PH_SEL: begin
            if (sel_hit) sel_cnt_q <= sel_cnt_q + CW'(1);
          end
          qrsbd_pkg::PH_SCAN: begin
            if (scan_hit && !found_q) begin
              found_q <= 1'b1;
              pos_q   <= rd_gaddr_q;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.sel_commit) begin
        if (sel_cnt_q <= kk_q) begin
          prefix_q[bit_q] <= 1'b1;
          kk_q            <= kk_q - sel_cnt_q;
        end
        if (bit_q != '0) bit_q <= bit_q - BW'(1);
      end
    end
  end

  // per-segment results and output register
  logic [30:0] onset_idx_q, end_idx_q, seg_idx;
  logic        onset_fnd_q, end_fnd_q;
  assign seg_idx = base_q + 31'(lo_q) + 31'(pos_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_commit) begin
      if (cmd_i.seg == qrsbd_pkg::SEG_ONSET) begin
        onset_idx_q <= found_q ? seg_idx : '0;
        onset_fnd_q <= found_q;
      end else begin
        end_idx_q <= found_q ? seg_idx : '0;
        end_fnd_q <= found_q;
      end
    end
    if (cmd_i.out_load) begin
      out_onset_index_o <= onset_idx_q;
      out_onset_found_o <= onset_fnd_q;
      out_end_index_o   <= end_idx_q;
      out_end_found_o   <= end_fnd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_o || out_ready_i;

  a_rank_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kk_q <= n_q)
    else $error("percentile rank beyond segment length");

  a_found_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(found_q) |-> $past(cmd_i.pass_run && cmd_i.phase == qrsbd_pkg::PH_SCAN))
    else $error("boundary flagged outside the scan pass");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten while still pending");

endmodule

FILE: hw/rtl/qrs_boundary_detector_top.sv
// QRS boundary detector: beat loading, onset and end search.
// Channels carry valid/ready. After the beat's last sample request the
// block computes, per side of the R peak (n samples, ng = n - 1 gradients):
//   gradient pass  over the n samples (sample store read port, one per cycle),
//   percentile     SAMPLE_BITS passes over the ng gradients (radix select over
//                  the gradient store, one bit per pass),
//   scan           one pass over the ng gradients,
// each side framed by setup and commit; a side shorter than two samples goes
// from setup straight to commit, and an output state releases the result.
// Loading takes one sample per cycle; no sample is taken while a beat is
// being evaluated. Each beat gives one result request.
// The output register holds a result until it is taken; the next beat loads
// meanwhile, and only its own result waits for the register to drain.
// Reset empties the beat, clears the output valid and sets search_window to 100.
// search_window is written over APB at byte address 0; write it only idle.
// Depends on qrsbd_pkg, qrsbd_if, qrsbd_ctrl, qrsbd_dp.
module qrs_boundary_detector_top #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  qrsbd_in_if.sink     in_if,
  qrsbd_out_if.source  out_if,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  qrsbd_pkg::cmd_t    cmd;
  qrsbd_pkg::status_t status;
  logic [8:0]         window_q;

  assign pready = 1'b1;
  assign prdata = (32'(paddr[2]) == qrsbd_pkg::REG_WINDOW) ? 32'(window_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= qrsbd_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && pready
                 && 32'(paddr[2]) == qrsbd_pkg::REG_WINDOW) begin
      window_q <= pwdata[8:0];
    end
  end

  qrsbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_last_i  (in_if.last),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  qrsbd_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .window_i          (window_q),
    .sample_i          (in_if.sample),
    .seg_start_i       (in_if.seg_start),
    .peak_offset_i     (in_if.peak_offset),
    .out_ready_i       (out_if.ready),
    .out_valid_o       (out_if.valid),
    .out_onset_index_o (out_if.onset_index),
    .out_onset_found_o (out_if.onset_found),
    .out_end_index_o   (out_if.end_index),
    .out_end_found_o   (out_if.end_found)
  );

endmodule

FILE: tb/qrsbd_checker.sv
// Checker for the QRS boundary detector: watches both request channels,
// predicts onset and end per beat and compares each result request.
// Depends on qrsbd_if.
`timescale 1ns / 100ps
module qrsbd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  qrsbd_in_if.sink    in_mon,
  qrsbd_out_if.sink   out_mon,
  input  logic [8:0]  window_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          beats_o
);

  typedef struct packed {
    logic [30:0] onset_index;
    logic        onset_found;
    logic [30:0] end_index;
    logic        end_found;
  } bounds_t;

  localparam int STORE_DEPTH = 512;

  logic signed [15:0] beat_samples [STORE_DEPTH];
  int unsigned        loaded = 0;
  logic [30:0]        beat_base = '0;
  int unsigned        peak_pos = 0;
  bounds_t            bounds_q [$];
  longint unsigned    grad_mag [STORE_DEPTH];
  int                 fails = 0;
  int                 results = 0;

  assign pending_o    = bounds_q.size();
  assign fail_count_o = fails;
  assign beats_o      = results;

  // returns 1 and the offset of the chosen gradient within [lo, hi)
  function automatic bit search_gradients(int unsigned lo, int unsigned hi,
                                          longint unsigned mul, bit backward,
                                          output int unsigned pos);
    int unsigned     ng;
    int unsigned     k;
    int unsigned     less_n;
    int unsigned     leq_n;
    int unsigned     t;
    longint          d;
    longint unsigned mx;
    longint unsigned pct;
    pos = 0;
    mx  = 0;
    pct = 0;
    if (hi > STORE_DEPTH || lo >= hi || hi - lo < 2) return 0;
    ng = hi - lo - 1;
    for (int i = 0; i < ng; i++) begin
      d = longint'(beat_samples[lo+i+1]) - longint'(beat_samples[lo+i]);
      grad_mag[i] = d < 0 ? -d : d;
      if (grad_mag[i] > mx) mx = grad_mag[i];
    end
    k = ng / 10;
    if (k > ng - 1) k = ng - 1;
    for (int j = 0; j < ng; j++) begin
      less_n = 0;
      leq_n  = 0;
      for (int i = 0; i < ng; i++) begin
        if (grad_mag[i] < grad_mag[j]) less_n++;
        if (grad_mag[i] <= grad_mag[j]) leq_n++;
      end
      if (less_n <= k && k < leq_n) begin
        pct = grad_mag[j];
        break;
      end
    end
    for (int i = 0; i < ng; i++) begin
      t = backward ? ng - 1 - i : i;
      if (mul * grad_mag[t] < mx || grad_mag[t] < pct) begin
        pos = t;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic bounds_t locate_bounds();
    bounds_t     b;
    int unsigned lo;
    int unsigned hi;
    int unsigned pos;
    int unsigned w;
    w  = window_i;
    lo = peak_pos > w ? peak_pos - w : 0;
    hi = peak_pos < loaded ? peak_pos : loaded;
    b.onset_found = search_gradients(lo, hi, 10, 1'b1, pos);
    b.onset_index = b.onset_found ? 31'(beat_base + lo + pos) : '0;
    lo = peak_pos;
    hi = peak_pos + w < loaded ? peak_pos + w : loaded;
    b.end_found = search_gradients(lo, hi, 20, 1'b0, pos);
    b.end_index = b.end_found ? 31'(beat_base + lo + pos) : '0;
    return b;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i) begin
    bounds_t b;
    if (rst_ni && in_mon.valid && in_mon.ready) begin
      if (loaded == 0) begin
        beat_base = in_mon.seg_start;
        peak_pos  = in_mon.peak_offset;
      end
      if (loaded < STORE_DEPTH) begin
        beat_samples[loaded] = in_mon.sample;
        loaded++;
      end
      if (in_mon.last) begin
        bounds_q = {bounds_q, locate_bounds()};
        loaded = 0;
      end
    end
    if (rst_ni && out_mon.valid && out_mon.ready) begin
      if (bounds_q.size() == 0) begin
        report_mismatch("result requests beyond expected", 32'd1, 32'd0);
      end else begin
        b = bounds_q.pop_front();
        results++;
        if (out_mon.onset_found !== b.onset_found)
          report_mismatch("onset_found", out_mon.onset_found, b.onset_found);
        if (out_mon.onset_index !== b.onset_index)
          report_mismatch("onset_index", out_mon.onset_index, b.onset_index);
        if (out_mon.end_found !== b.end_found)
          report_mismatch("end_found", out_mon.end_found, b.end_found);
        if (out_mon.end_index !== b.end_index)
          report_mismatch("end_index", out_mon.end_index, b.end_index);
      end
    end
  end

endmodule

FILE: tb/qrs_boundary_detector_top_tb.sv
// Testbench top for the QRS boundary detector: drives beats and APB writes
// to search_window, applies idle and stall phases, gives the verdict.
// Depends on qrsbd_pkg, qrsbd_if, qrsbd_checker, qrs_boundary_detector_top.
`timescale 1ns / 100ps
module qrs_boundary_detector_top_tb;

  localparam int SHAPE_QRS     = 0;
  localparam int SHAPE_FLAT    = 1;
  localparam int SHAPE_RANDOM  = 2;
  localparam int SHAPE_EXTREME = 3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [8:0]  window = qrsbd_pkg::WINDOW_RESET;
  int          fail_count;
  int          pending;
  int          beats;
  int          items_sent;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_off = 1'b0;

  qrsbd_in_if  in_if();
  qrsbd_out_if out_if();

  qrs_boundary_detector_top dut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  qrsbd_checker chk (
    .clk_i, .rst_ni, .in_mon(in_if.sink), .out_mon(out_if.sink),
    .window_i(window), .fail_count_o(fail_count), .pending_o(pending),
    .beats_o(beats)
  );

  always #2 clk_i = ~clk_i;

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    out_if.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  task automatic write_window(input logic [8:0] value);
    @(negedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= 3'(qrsbd_pkg::REG_WINDOW * 4);
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    window = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one sample request; called at a falling edge, returns at a falling edge
  task automatic send_sample(input logic signed [15:0] s, input logic [30:0] start,
                             input logic [8:0] peak, input bit is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= s;
    in_if.seg_start   <= start;
    in_if.peak_offset <= peak;
    in_if.last        <= is_last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_beat(input int n, input int peak, input int shape,
                           input logic [30:0] start);
    logic signed [15:0] s;
    int                 d;
    for (int i = 0; i < n; i++) begin
      d = i - peak;
      case (shape)
        SHAPE_QRS: s = 16'(($urandom_range(40) - 20)
                           + (d * d < 64 ? 2000 - 30 * d * d : 0));
        SHAPE_FLAT: s = 16'sd7;
        SHAPE_RANDOM: s = 16'($urandom);
        default: s = (i % 2) ? 16'sh7fff : 16'sh8000;
      endcase
      send_sample(s, start, 9'(peak), i == n - 1);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2 * 18 * 512 + 50) @(negedge clk_i);
  endtask

  task automatic random_beats(input int count);
    int n;
    int pk;
    int w;
    w = window;
    for (int b = 0; b < count; b++) begin
      n  = $urandom_range(9) == 0 ? $urandom_range(2 * w + 4, 1) : $urandom_range(12, 1);
      pk = $urandom_range(3) == 0 ? $urandom_range(511) : $urandom_range(n);
      send_beat(n, pk, $urandom_range(3), 31'($urandom));
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.sample = '0;
    in_if.seg_start = '0;
    in_if.peak_offset = '0;
    in_if.last = 1'b0;
    items_sent = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // directed: short beats, extremes, flat, wrap of the index
    send_beat(1, 0, SHAPE_RANDOM, '0);
    send_beat(2, 1, SHAPE_EXTREME, 31'h7fff_ffff);
    send_beat(6, 3, SHAPE_FLAT, 31'h7fff_fffe);
    send_beat(8, 4, SHAPE_QRS, 31'h5555_5555);
    send_beat(5, 9'h1ff, SHAPE_RANDOM, 31'h2aaa_aaaa);
    drain();
    write_window(9'd2);
    send_beat(6, 3, SHAPE_QRS, 31'd100);
    drain();
    write_window(9'd256);
    send_beat(514, 256, SHAPE_QRS, 31'd1000);   // overflows the store
    drain();
    write_window(9'h1ff);
    send_beat(8, 4, SHAPE_RANDOM, 31'd7);
    drain();
    write_window(9'd0);
    send_beat(4, 2, SHAPE_RANDOM, 31'd7);
    drain();
    write_window(9'd1);
    send_beat(4, 2, SHAPE_QRS, 31'd7);
    drain();
    write_window(9'd12);
    random_beats(4);
    send_idle_pct = 51;
    random_beats(4);
    send_idle_pct = 0;
    stall_pct = 51;
    random_beats(4);
    send_idle_pct = 21;
    stall_pct = 21;
    drain();
    write_window(9'd5);
    random_beats(4);
    // long hold-off: the output register fills and the block stalls input
    send_idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_beats(6);
    join
    drain();
    write_window(qrsbd_pkg::WINDOW_RESET);
    random_beats(4);
    drain();
    $display("Covered %0d sample requests and %0d beat results", items_sent, beats);
    $display("Windows 0, 1, 2, 5, 12, 100, 256, 511 with idle and stall phases");
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/qrsbd_pkg.sv
hw/rtl/qrsbd_if.sv
hw/rtl/qrsbd_ctrl.sv
hw/rtl/qrsbd_dp.sv
hw/rtl/qrs_boundary_detector_top.sv
tb/qrsbd_checker.sv
tb/qrs_boundary_detector_top_tb.sv
